/* design/range_add_range_min_tree_unit_defines.svh */
// ----------------------------------------------------------------------------
// Range add / range min tree unit - assertion macros
// Shared concurrent assertion forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef RANGE_ADD_RANGE_MIN_TREE_UNIT_DEFINES_SVH
`define RANGE_ADD_RANGE_MIN_TREE_UNIT_DEFINES_SVH

// General form: explicit clock and active-low reset.
`define RARMT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Short form on the block clock and reset.
`define RARMT_ASSERT_CLK(lbl, prop, msg) \
    `RARMT_ASSERT(lbl, i_clk, i_rst_n, prop, msg)

`endif

/* design/rarmt_pkg.sv */
// ----------------------------------------------------------------------------
// rarmt_pkg
// Types, constants and arithmetic helpers for the range add / range min tree.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rarmt_pkg;

    localparam int LEAF_COUNT_DEF = 1024;
    localparam int POS_W          = 11;
    localparam int VAL_W          = 64;
    localparam int IN_W           = 104;
    localparam int OUT_W          = 64;

    // Input item bit positions
    localparam int CMD_LSB  = 0;
    localparam int LO_LSB   = 2;
    localparam int HI_LSB   = 13;
    localparam int POS_LSB  = 24;
    localparam int AMT_LSB  = 35;

    localparam logic signed [VAL_W-1:0] VAL_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [VAL_W-1:0] VAL_MIN = 64'sh8000_0000_0000_0000;

    typedef enum logic [1:0] {
        CMD_SET   = 2'd0,
        CMD_ADD   = 2'd1,
        CMD_QUERY = 2'd2,
        CMD_RSVD  = 2'd3
    } t_cmd_code;

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_DECODE,
        ST_PCHK, ST_P0, ST_P1, ST_P2, ST_P3, ST_P4, ST_PNEXT,
        ST_ACHK, ST_ARD, ST_AWR, ST_SETW,
        ST_UINIT, ST_UCHK, ST_U0, ST_U1, ST_U2, ST_UNEXT,
        ST_OUT
    } t_state;

    typedef enum logic [4:0] {
        DP_NOP, DP_CLR, DP_LOAD, DP_INIT,
        DP_P0, DP_P1, DP_P2, DP_P3, DP_P4, DP_NEXT1,
        DP_ACHK, DP_ARD, DP_AWR, DP_SET,
        DP_UINIT, DP_U0, DP_U1, DP_U2, DP_NEXT3
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_done;
        logic is_set;
        logic is_query;
        logic op_valid;
        logic need;
        logic last1;
        logic last3;
        logic p_zero;
        logic a_done;
        logic a_hit;
    } t_dp_status;

    function automatic logic signed [VAL_W-1:0] sat_add(
        input logic signed [VAL_W-1:0] a,
        input logic signed [VAL_W-1:0] b
    );
        logic signed [VAL_W:0] s;
        s = {a[VAL_W-1], a} + {b[VAL_W-1], b};
        if (s[VAL_W] != s[VAL_W-1]) begin
            sat_add = s[VAL_W] ? VAL_MIN : VAL_MAX;
        end else begin
            sat_add = s[VAL_W-1:0];
        end
    endfunction

    function automatic logic signed [VAL_W-1:0] min2(
        input logic signed [VAL_W-1:0] a,
        input logic signed [VAL_W-1:0] b
    );
        min2 = (a < b) ? a : b;
    endfunction

endpackage

/* design/rarmt_ram.sv */
// ----------------------------------------------------------------------------
// rarmt_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rarmt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* design/rarmt_ctrl.sv */
// ----------------------------------------------------------------------------
// rarmt_ctrl
// Sequencer: clear pass, push-down, apply and update phases, result hand-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rarmt_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    input  rarmt_pkg::t_dp_status i_status,
    output rarmt_pkg::t_dp_cmd    o_cmd
);

    rarmt_pkg::t_state r_state;
    rarmt_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rarmt_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd.op   = rarmt_pkg::DP_NOP;
        o_s_tready = 1'b0;
        o_m_tvalid = 1'b0;
        unique case (r_state)
            rarmt_pkg::ST_CLEAR: begin
                o_cmd.op = rarmt_pkg::DP_CLR;
                if (i_status.clr_done) n_state = rarmt_pkg::ST_IDLE;
            end
            rarmt_pkg::ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.op = rarmt_pkg::DP_LOAD;
                    n_state  = rarmt_pkg::ST_DECODE;
                end
            end
            rarmt_pkg::ST_DECODE: begin
                o_cmd.op = rarmt_pkg::DP_INIT;
                if (i_status.op_valid) n_state = rarmt_pkg::ST_PCHK;
                else if (i_status.is_query) n_state = rarmt_pkg::ST_OUT;
                else n_state = rarmt_pkg::ST_IDLE;
            end
            rarmt_pkg::ST_PCHK: begin
                n_state = i_status.need ? rarmt_pkg::ST_P0 : rarmt_pkg::ST_PNEXT;
            end
            rarmt_pkg::ST_P0: begin
                o_cmd.op = rarmt_pkg::DP_P0;
                n_state  = rarmt_pkg::ST_P1;
            end
            rarmt_pkg::ST_P1: begin
                o_cmd.op = rarmt_pkg::DP_P1;
                // nothing owed: skip the child writes
                n_state  = i_status.p_zero ? rarmt_pkg::ST_PNEXT : rarmt_pkg::ST_P2;
            end
            rarmt_pkg::ST_P2: begin
                o_cmd.op = rarmt_pkg::DP_P2;
                n_state  = rarmt_pkg::ST_P3;
            end
            rarmt_pkg::ST_P3: begin
                o_cmd.op = rarmt_pkg::DP_P3;
                n_state  = rarmt_pkg::ST_P4;
            end
            rarmt_pkg::ST_P4: begin
                o_cmd.op = rarmt_pkg::DP_P4;
                n_state  = rarmt_pkg::ST_PNEXT;
            end
            rarmt_pkg::ST_PNEXT: begin
                o_cmd.op = rarmt_pkg::DP_NEXT1;
                if (i_status.last1) begin
                    n_state = i_status.is_set ? rarmt_pkg::ST_SETW : rarmt_pkg::ST_ACHK;
                end else begin
                    n_state = rarmt_pkg::ST_PCHK;
                end
            end
            rarmt_pkg::ST_ACHK: begin
                o_cmd.op = rarmt_pkg::DP_ACHK;
                if (i_status.a_done) begin
                    n_state = i_status.is_query ? rarmt_pkg::ST_OUT : rarmt_pkg::ST_UINIT;
                end else if (i_status.a_hit) begin
                    n_state = rarmt_pkg::ST_ARD;
                end
            end
            rarmt_pkg::ST_ARD: begin
                o_cmd.op = rarmt_pkg::DP_ARD;
                n_state  = rarmt_pkg::ST_AWR;
            end
            rarmt_pkg::ST_AWR: begin
                o_cmd.op = rarmt_pkg::DP_AWR;
                n_state  = rarmt_pkg::ST_ACHK;
            end
            rarmt_pkg::ST_SETW: begin
                o_cmd.op = rarmt_pkg::DP_SET;
                n_state  = rarmt_pkg::ST_UINIT;
            end
            rarmt_pkg::ST_UINIT: begin
                o_cmd.op = rarmt_pkg::DP_UINIT;
                n_state  = rarmt_pkg::ST_UCHK;
            end
            rarmt_pkg::ST_UCHK: begin
                n_state = i_status.need ? rarmt_pkg::ST_U0 : rarmt_pkg::ST_UNEXT;
            end
            rarmt_pkg::ST_U0: begin
                o_cmd.op = rarmt_pkg::DP_U0;
                n_state  = rarmt_pkg::ST_U1;
            end
            rarmt_pkg::ST_U1: begin
                o_cmd.op = rarmt_pkg::DP_U1;
                n_state  = rarmt_pkg::ST_U2;
            end
            rarmt_pkg::ST_U2: begin
                o_cmd.op = rarmt_pkg::DP_U2;
                n_state  = rarmt_pkg::ST_UNEXT;
            end
            rarmt_pkg::ST_UNEXT: begin
                o_cmd.op = rarmt_pkg::DP_NEXT3;
                n_state  = i_status.last3 ? rarmt_pkg::ST_IDLE : rarmt_pkg::ST_UCHK;
            end
            rarmt_pkg::ST_OUT: begin
                o_m_tvalid = 1'b1;
                if (i_m_tready) n_state = rarmt_pkg::ST_IDLE;
            end
            default: begin
                n_state = rarmt_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

/* design/rarmt_dp.sv */
// ----------------------------------------------------------------------------
// rarmt_dp
// Datapath: node minimum and pending addend memories, boundary walk, result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rarmt_dp #(
    parameter int LEAF_COUNT = rarmt_pkg::LEAF_COUNT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rarmt_pkg::t_dp_cmd            i_cmd,
    input  logic [rarmt_pkg::IN_W-1:0]    i_tdata,
    output rarmt_pkg::t_dp_status         o_status,
    output logic [rarmt_pkg::OUT_W-1:0]   o_result
);

    localparam int LOG  = $clog2(LEAF_COUNT);
    localparam int NW   = LOG + 1;
    localparam int RW   = LOG + 2;
    localparam int LVW  = $clog2(LOG + 1);
    localparam int PW   = rarmt_pkg::POS_W;
    localparam int VW   = rarmt_pkg::VAL_W;
    localparam int CW   = (PW + 1 > RW) ? PW + 1 : RW;

    // Input fields
    logic [1:0]    in_cmd;
    logic [PW-1:0] in_lo, in_hi, in_pos;
    logic [VW-1:0] in_amt;
    logic [CW-1:0] lo_c, hi_c, pos_c, leaf_c, lo_cl, hi_cl;
    logic [CW-1:0] l_rng, r_rng, l_pos, r_pos;
    logic          rng_ok, pos_ok, in_valid;

    // Item registers
    rarmt_pkg::t_cmd_code   r_kind;
    logic signed [VW-1:0]   r_x;
    logic                   r_force;
    logic                   r_valid;
    logic [NW-1:0]          r_l;
    logic [RW-1:0]          r_r;

    // Walk registers
    logic [LVW-1:0]         r_lvl;
    logic                   r_side;
    logic [RW-1:0]          r_l2, r_r2;
    logic [NW-1:0]          r_node;
    logic                   r_aside;
    logic signed [VW-1:0]   r_p, r_c, r_acc;
    logic [NW-1:0]          r_clr;

    logic [RW-1:0]          mask, l_ext;
    logic [NW-1:0]          node, child0, child1;
    logic                   need0, need1, step_end;

    // Memory ports
    logic [NW-1:0]          raddr, waddr;
    logic                   min_we, pend_we;
    logic [VW-1:0]          min_wd, pend_wd, min_q, pend_q;
    logic signed [VW-1:0]   min_qs, pend_qs;

    function automatic logic [VW-1:0] sat_sel(
        input logic signed [VW-1:0] a,
        input logic signed [VW-1:0] b
    );
        sat_sel = rarmt_pkg::sat_add(a, b);
    endfunction

    assign in_cmd = i_tdata[rarmt_pkg::CMD_LSB +: 2];
    assign in_lo  = i_tdata[rarmt_pkg::LO_LSB +: PW];
    assign in_hi  = i_tdata[rarmt_pkg::HI_LSB +: PW];
    assign in_pos = i_tdata[rarmt_pkg::POS_LSB +: PW];
    assign in_amt = i_tdata[rarmt_pkg::AMT_LSB +: VW];

    assign lo_c   = CW'(in_lo);
    assign hi_c   = CW'(in_hi);
    assign pos_c  = CW'(in_pos);
    assign leaf_c = CW'(LEAF_COUNT);

    // Clip the range to the positions that exist
    assign rng_ok = (lo_c <= hi_c) && (lo_c <= leaf_c) && (hi_c != '0);
    assign lo_cl  = (lo_c == '0) ? CW'(1) : lo_c;
    assign hi_cl  = (hi_c > leaf_c) ? leaf_c : hi_c;
    assign l_rng  = leaf_c + lo_cl - CW'(1);
    assign r_rng  = leaf_c + hi_cl;
    assign pos_ok = (pos_c != '0) && (pos_c <= leaf_c);
    assign l_pos  = leaf_c + pos_c - CW'(1);
    assign r_pos  = l_pos + CW'(1);

    always_comb begin
        case (in_cmd)
            rarmt_pkg::CMD_SET:   in_valid = pos_ok;
            rarmt_pkg::CMD_ADD:   in_valid = rng_ok;
            rarmt_pkg::CMD_QUERY: in_valid = rng_ok;
            default:              in_valid = 1'b0;
        endcase
    end

    // Boundary node at the current level and side
    assign mask     = (RW'(1) << r_lvl) - RW'(1);
    assign l_ext    = RW'(r_l);
    assign need0    = r_force || ((l_ext & mask) != '0);
    assign need1    = (r_r & mask) != '0;
    assign node     = r_side ? NW'((r_r - RW'(1)) >> r_lvl) : NW'(l_ext >> r_lvl);
    assign child0   = {node[NW-2:0], 1'b0};
    assign child1   = {node[NW-2:0], 1'b1};
    assign step_end = r_side || r_force;

    assign min_qs  = $signed(min_q);
    assign pend_qs = $signed(pend_q);

    assign o_status.clr_done = (r_clr == {NW{1'b1}});
    assign o_status.is_set   = (r_kind == rarmt_pkg::CMD_SET);
    assign o_status.is_query = (r_kind == rarmt_pkg::CMD_QUERY);
    assign o_status.op_valid = r_valid;
    assign o_status.need     = r_side ? need1 : need0;
    assign o_status.last1    = (r_lvl == LVW'(1)) && step_end;
    assign o_status.last3    = (r_lvl == LVW'(LOG)) && step_end;
    assign o_status.p_zero   = (pend_q == '0);
    assign o_status.a_done   = !(r_l2 < r_r2);
    assign o_status.a_hit    = r_l2[0] | r_r2[0];

    assign o_result = r_acc;

    // Memory address and write selection
    always_comb begin
        raddr   = node;
        waddr   = node;
        min_we  = 1'b0;
        pend_we = 1'b0;
        min_wd  = sat_sel(min_qs, r_p);
        pend_wd = sat_sel(pend_qs, r_p);
        unique case (i_cmd.op)
            rarmt_pkg::DP_CLR: begin
                waddr   = r_clr;
                min_we  = 1'b1;
                pend_we = 1'b1;
                min_wd  = rarmt_pkg::VAL_MAX;
                pend_wd = '0;
            end
            rarmt_pkg::DP_P0: raddr = node;
            rarmt_pkg::DP_P1: raddr = child0;
            rarmt_pkg::DP_P2: begin
                raddr   = child1;
                waddr   = child0;
                min_we  = 1'b1;
                pend_we = 1'b1;
            end
            rarmt_pkg::DP_P3: begin
                waddr   = child1;
                min_we  = 1'b1;
                pend_we = 1'b1;
            end
            rarmt_pkg::DP_P4: begin
                waddr   = node;
                pend_we = 1'b1;
                pend_wd = '0;
            end
            rarmt_pkg::DP_ARD: raddr = r_node;
            rarmt_pkg::DP_AWR: begin
                waddr   = r_node;
                min_we  = (r_kind == rarmt_pkg::CMD_ADD);
                pend_we = (r_kind == rarmt_pkg::CMD_ADD);
                min_wd  = sat_sel(min_qs, r_x);
                pend_wd = sat_sel(pend_qs, r_x);
            end
            rarmt_pkg::DP_SET: begin
                waddr   = r_l;
                min_we  = 1'b1;
                pend_we = 1'b1;
                min_wd  = r_x;
                pend_wd = '0;
            end
            rarmt_pkg::DP_U0: raddr = child0;
            rarmt_pkg::DP_U1: raddr = child1;
            rarmt_pkg::DP_U2: begin
                waddr  = node;
                min_we = 1'b1;
                min_wd = rarmt_pkg::min2(r_c, min_qs);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.op == rarmt_pkg::DP_CLR) begin
            r_clr <= r_clr + NW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            rarmt_pkg::DP_LOAD: begin
                r_kind  <= rarmt_pkg::t_cmd_code'(in_cmd);
                r_x     <= $signed(in_amt);
                r_force <= (in_cmd == rarmt_pkg::CMD_SET);
                r_valid <= in_valid;
                if (in_cmd == rarmt_pkg::CMD_SET) begin
                    r_l <= NW'(l_pos);
                    r_r <= RW'(r_pos);
                end else begin
                    r_l <= NW'(l_rng);
                    r_r <= RW'(r_rng);
                end
            end
            rarmt_pkg::DP_INIT: begin
                r_lvl  <= LVW'(LOG);
                r_side <= 1'b0;
                r_l2   <= l_ext;
                r_r2   <= r_r;
                r_acc  <= rarmt_pkg::VAL_MAX;
            end
            rarmt_pkg::DP_P1: r_p <= pend_qs;
            rarmt_pkg::DP_NEXT1: begin
                // advance to the other side, then down one level toward the leaves
                if (step_end) begin
                    r_side <= 1'b0;
                    r_lvl  <= r_lvl - LVW'(1);
                end else begin
                    r_side <= 1'b1;
                end
            end
            rarmt_pkg::DP_ACHK: begin
                if (r_l2 < r_r2) begin
                    if (r_l2[0]) begin
                        r_node  <= NW'(r_l2);
                        r_aside <= 1'b0;
                    end else if (r_r2[0]) begin
                        r_node  <= NW'(r_r2 - RW'(1));
                        r_aside <= 1'b1;
                    end else begin
                        r_l2 <= r_l2 >> 1;
                        r_r2 <= r_r2 >> 1;
                    end
                end
            end
            rarmt_pkg::DP_AWR: begin
                if (r_kind == rarmt_pkg::CMD_QUERY) begin
                    r_acc <= rarmt_pkg::min2(r_acc, min_qs);
                end
                if (r_aside) r_r2 <= r_r2 - RW'(1);
                else         r_l2 <= r_l2 + RW'(1);
            end
            rarmt_pkg::DP_UINIT: begin
                r_lvl  <= LVW'(1);
                r_side <= 1'b0;
            end
            rarmt_pkg::DP_U1: r_c <= min_qs;
            rarmt_pkg::DP_NEXT3: begin
                if (step_end) begin
                    r_side <= 1'b0;
                    r_lvl  <= r_lvl + LVW'(1);
                end else begin
                    r_side <= 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    rarmt_ram #(
        .WIDTH (VW),
        .DEPTH (2 * LEAF_COUNT)
    ) u_min_ram (
        .i_clk   (i_clk),
        .i_we    (min_we),
        .i_waddr (waddr),
        .i_wdata (min_wd),
        .i_raddr (raddr),
        .o_rdata (min_q)
    );

    rarmt_ram #(
        .WIDTH (VW),
        .DEPTH (2 * LEAF_COUNT)
    ) u_pend_ram (
        .i_clk   (i_clk),
        .i_we    (pend_we),
        .i_waddr (waddr),
        .i_wdata (pend_wd),
        .i_raddr (raddr),
        .o_rdata (pend_q)
    );

endmodule

/* design/range_add_range_min_tree_unit.sv */
// ----------------------------------------------------------------------------
// range_add_range_min_tree_unit
// Lazy range-add / range-minimum tree over positions 1..LEAF_COUNT.
// ----------------------------------------------------------------------------
// Input stream (s side) carries one command item: set a position, add a
// signed amount to an inclusive range, or query the range minimum. Only a
// query produces an output item (m side) holding the 64-bit minimum.
// After reset the block sweeps every address of both node memories, one
// node per cycle; o_s_tready stays low during the sweep.
// One item is in flight at a time. Each node access is a read-modify-write
// on single-write-port memories, so the time per item grows with the tree
// depth LOG = log2(LEAF_COUNT). A set pushes pending addends down the
// path, writes the leaf and updates its ancestors; a query pushes down and
// then gathers the minimum over the range; an add pushes down, applies the
// amount and updates the ancestors. A push with nothing owed skips the
// child writes, and a node that needs no push is skipped.
// Empty adds, ignored sets and unused command codes return straight to
// idle, and an empty query returns the maximum signed value.
// A query result waits in its output register while o_m_tvalid is high;
// the input side stays closed until i_m_tready takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module range_add_range_min_tree_unit #(
    parameter int LEAF_COUNT = rarmt_pkg::LEAF_COUNT_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    // [1:0] cmd, [12:2] range_low, [23:13] range_high, [34:24] position,
    // [98:35] amount, [103:99] zero
    input  logic [rarmt_pkg::IN_W-1:0]  i_s_tdata,
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    // [63:0] range_minimum
    output logic [rarmt_pkg::OUT_W-1:0] o_m_tdata
);

    rarmt_pkg::t_dp_cmd    dp_cmd;
    rarmt_pkg::t_dp_status dp_status;

    rarmt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd)
    );

    rarmt_dp #(
        .LEAF_COUNT (LEAF_COUNT)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (dp_cmd),
        .i_tdata  (i_s_tdata),
        .o_status (dp_status),
        .o_result (o_m_tdata)
    );

endmodule

/* design/rarmt_checker.sv */
// ----------------------------------------------------------------------------
// rarmt_checker
// Port-level checks for the range add / range min tree unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "range_add_range_min_tree_unit_defines.svh"

module rarmt_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_s_tvalid,
    input logic                        o_s_tready,
    input logic                        o_m_tvalid,
    input logic                        i_m_tready,
    input logic [rarmt_pkg::OUT_W-1:0] o_m_tdata
);

    // Hold a stalled result
    `RARMT_ASSERT_CLK(a_m_hold, o_m_tvalid && !i_m_tready |=> o_m_tvalid, "result dropped")
    `RARMT_ASSERT_CLK(a_m_stable, o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata), "result changed")
    // Never open the input while a result waits
    `RARMT_ASSERT_CLK(a_excl, !(o_s_tready && o_m_tvalid), "input open with result pending")
    // One item in flight: close the input right after an accept
    `RARMT_ASSERT_CLK(a_busy, i_s_tvalid && o_s_tready |=> !o_s_tready, "second item taken")

endmodule

bind range_add_range_min_tree_unit rarmt_checker u_rarmt_checker (.*);
